@@ rtl/sbq_pkg.sv @@
package sbq_pkg;

    localparam int SAMPLE_BITS_DEF     = 24;
    localparam int COEFF_FRAC_BITS_DEF = 22;
    localparam int DELAY_BITS          = 48;
    localparam int CFG_IDX_BITS        = 3;
    localparam int UNIT_BITS           = 2;
    localparam int NUM_UNITS           = 1 << UNIT_BITS;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_LP_EN = 3'd0,
        CFG_HP_EN = 3'd1,
        CFG_LP_B0 = 3'd2,
        CFG_LP_A1 = 3'd3,
        CFG_LP_A2 = 3'd4,
        CFG_HP_B0 = 3'd5,
        CFG_HP_A1 = 3'd6,
        CFG_HP_A2 = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MUL_B0 = 2'd0,
        MUL_A1 = 2'd1,
        MUL_A2 = 2'd2
    } t_mul_sel;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEL,
        ST_MUL_B,
        ST_ACC,
        ST_MUL_A1,
        ST_MUL_A2,
        ST_UPD2,
        ST_DONE
    } t_state;

    // unit = {channel, stage}, stage 0 lowpass, 1 highpass
    typedef struct packed {
        logic                 load_in;
        logic                 mul_en;
        t_mul_sel             mul_sel;
        logic                 acc_en;
        logic                 z1_en;
        logic                 z2_en;
        logic                 load_out;
        logic [UNIT_BITS-1:0] unit;
    } t_cmd;

    typedef struct packed {
        logic lp_en;
        logic hp_en;
    } t_sts;

endpackage

@@ rtl/sbq_ctrl.sv @@
module sbq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  sbq_pkg::t_sts   i_sts,
    output sbq_pkg::t_cmd   o_cmd
);

    sbq_pkg::t_state                 r_state, n_state;
    logic [sbq_pkg::UNIT_BITS-1:0]   r_unit, n_unit;
    logic                            r_out_valid, n_out_valid;
    logic                            unit_en;
    logic                            last_unit;
    logic                            slot_free;

    assign unit_en   = r_unit[0] ? i_sts.hp_en : i_sts.lp_en;
    assign last_unit = (r_unit == {sbq_pkg::UNIT_BITS{1'b1}});
    assign slot_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sbq_pkg::ST_IDLE;
            r_unit      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_unit      <= n_unit;
            r_out_valid <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_unit  = r_unit;
        case (r_state)
            sbq_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = sbq_pkg::ST_SEL;
                    n_unit  = '0;
                end
            end
            sbq_pkg::ST_SEL: begin
                if (unit_en) begin
                    n_state = sbq_pkg::ST_MUL_B;
                end else if (last_unit) begin
                    n_state = sbq_pkg::ST_DONE;
                end else begin
                    n_unit = r_unit + sbq_pkg::UNIT_BITS'(1);
                end
            end
            sbq_pkg::ST_MUL_B:  n_state = sbq_pkg::ST_ACC;
            sbq_pkg::ST_ACC:    n_state = sbq_pkg::ST_MUL_A1;
            sbq_pkg::ST_MUL_A1: n_state = sbq_pkg::ST_MUL_A2;
            sbq_pkg::ST_MUL_A2: n_state = sbq_pkg::ST_UPD2;
            sbq_pkg::ST_UPD2: begin
                if (last_unit) begin
                    n_state = sbq_pkg::ST_DONE;
                end else begin
                    n_state = sbq_pkg::ST_SEL;
                    n_unit  = r_unit + sbq_pkg::UNIT_BITS'(1);
                end
            end
            sbq_pkg::ST_DONE: begin
                if (slot_free) begin
                    n_state = sbq_pkg::ST_IDLE;
                end
            end
            default: n_state = sbq_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd          = '0;
        o_cmd.mul_sel  = sbq_pkg::MUL_B0;
        o_cmd.unit     = r_unit;
        o_in_stall     = 1'b1;
        case (r_state)
            sbq_pkg::ST_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.load_in = i_in_valid;
            end
            sbq_pkg::ST_MUL_B: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = sbq_pkg::MUL_B0;
            end
            sbq_pkg::ST_ACC: begin
                o_cmd.acc_en = 1'b1;
            end
            sbq_pkg::ST_MUL_A1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = sbq_pkg::MUL_A1;
            end
            sbq_pkg::ST_MUL_A2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = sbq_pkg::MUL_A2;
                o_cmd.z1_en   = 1'b1;
            end
            sbq_pkg::ST_UPD2: begin
                o_cmd.z2_en = 1'b1;
            end
            sbq_pkg::ST_DONE: begin
                o_cmd.load_out = slot_free;
            end
            default: o_cmd.load_in = 1'b0;
        endcase
    end

    assign n_out_valid = o_cmd.load_out || (r_out_valid && i_out_stall);
    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/sbq_dp.sv @@
module sbq_dp #(
    parameter int SAMPLE_BITS     = sbq_pkg::SAMPLE_BITS_DEF,
    parameter int COEFF_FRAC_BITS = sbq_pkg::COEFF_FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [sbq_pkg::CFG_IDX_BITS-1:0]       i_cfg_idx,
    input  logic [COEFF_FRAC_BITS+2:0]             i_cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]          i_left_sample,
    input  logic signed [SAMPLE_BITS-1:0]          i_right_sample,
    input  sbq_pkg::t_cmd                          i_cmd,
    output sbq_pkg::t_sts                          o_sts,
    output logic signed [SAMPLE_BITS-1:0]          o_left_result,
    output logic signed [SAMPLE_BITS-1:0]          o_right_result
);

    localparam int COEFF_BITS = COEFF_FRAC_BITS + 3;
    localparam int PROD_BITS  = COEFF_BITS + SAMPLE_BITS;
    localparam int DB         = sbq_pkg::DELAY_BITS;
    localparam int ACC_BITS   = ((PROD_BITS > DB) ? PROD_BITS : DB) + 3;

    localparam logic signed [ACC_BITS-1:0] ROUND =
        ACC_BITS'(1) << (COEFF_FRAC_BITS - 1);
    localparam logic signed [ACC_BITS-1:0] Y_MAX =
        (ACC_BITS'(1) << (SAMPLE_BITS - 1)) - ACC_BITS'(1);
    localparam logic signed [ACC_BITS-1:0] Y_MIN =
        -(ACC_BITS'(1) << (SAMPLE_BITS - 1));
    localparam logic signed [ACC_BITS-1:0] D_MAX =
        (ACC_BITS'(1) << (DB - 1)) - ACC_BITS'(1);
    localparam logic signed [ACC_BITS-1:0] D_MIN =
        -(ACC_BITS'(1) << (DB - 1));
    localparam logic [COEFF_BITS-1:0] COEFF_ONE = COEFF_BITS'(1) << COEFF_FRAC_BITS;

    logic                          r_lp_en, r_hp_en;
    logic signed [COEFF_BITS-1:0]  r_lp_b0, r_lp_a1, r_lp_a2;
    logic signed [COEFF_BITS-1:0]  r_hp_b0, r_hp_a1, r_hp_a2;

    logic signed [DB-1:0]          r_z1 [sbq_pkg::NUM_UNITS];
    logic signed [DB-1:0]          r_z2 [sbq_pkg::NUM_UNITS];

    logic signed [SAMPLE_BITS-1:0] r_x [2];
    logic signed [SAMPLE_BITS-1:0] r_y;
    logic signed [SAMPLE_BITS-1:0] r_out [2];
    logic signed [PROD_BITS-1:0]   r_prod;
    logic signed [PROD_BITS-1:0]   r_bx;

    logic                          stage;
    logic                          chan;
    logic signed [COEFF_BITS-1:0]  mul_coef;
    logic signed [SAMPLE_BITS-1:0] mul_op;
    logic signed [ACC_BITS-1:0]    acc;
    logic signed [ACC_BITS-1:0]    acc_sh;
    logic signed [SAMPLE_BITS-1:0] y_sat;
    logic signed [ACC_BITS-1:0]    prod_ext;
    logic signed [ACC_BITS-1:0]    bx_ext;
    logic signed [ACC_BITS-1:0]    z2_ext;
    logic signed [ACC_BITS-1:0]    z1_sum;
    logic signed [ACC_BITS-1:0]    z2_sum;
    logic signed [DB-1:0]          z1_sat;
    logic signed [DB-1:0]          z2_sat;

    assign stage = i_cmd.unit[0];
    assign chan  = i_cmd.unit[1];

    assign o_sts.lp_en = r_lp_en;
    assign o_sts.hp_en = r_hp_en;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp_en <= 1'b0;
            r_hp_en <= 1'b0;
            r_lp_b0 <= COEFF_ONE;
            r_lp_a1 <= '0;
            r_lp_a2 <= '0;
            r_hp_b0 <= COEFF_ONE;
            r_hp_a1 <= '0;
            r_hp_a2 <= '0;
        end else if (i_cfg_we) begin
            case (sbq_pkg::t_cfg_idx'(i_cfg_idx))
                sbq_pkg::CFG_LP_EN: r_lp_en <= i_cfg_data[0];
                sbq_pkg::CFG_HP_EN: r_hp_en <= i_cfg_data[0];
                sbq_pkg::CFG_LP_B0: r_lp_b0 <= i_cfg_data;
                sbq_pkg::CFG_LP_A1: r_lp_a1 <= i_cfg_data;
                sbq_pkg::CFG_LP_A2: r_lp_a2 <= i_cfg_data;
                sbq_pkg::CFG_HP_B0: r_hp_b0 <= i_cfg_data;
                sbq_pkg::CFG_HP_A1: r_hp_a1 <= i_cfg_data;
                sbq_pkg::CFG_HP_A2: r_hp_a2 <= i_cfg_data;
                default: r_lp_en <= r_lp_en;
            endcase
        end
    end

    // shared multiplier operands
    always_comb begin
        case (i_cmd.mul_sel)
            sbq_pkg::MUL_B0: mul_coef = stage ? r_hp_b0 : r_lp_b0;
            sbq_pkg::MUL_A1: mul_coef = stage ? r_hp_a1 : r_lp_a1;
            sbq_pkg::MUL_A2: mul_coef = stage ? r_hp_a2 : r_lp_a2;
            default:         mul_coef = '0;
        endcase
        mul_op = (i_cmd.mul_sel == sbq_pkg::MUL_B0) ? r_x[chan] : r_y;
    end

    // stage output: round, shift, saturate
    always_comb begin
        acc    = ACC_BITS'(r_prod) + ACC_BITS'(r_z1[i_cmd.unit]) + ROUND;
        acc_sh = acc >>> COEFF_FRAC_BITS;
        if (acc_sh > Y_MAX) begin
            y_sat = Y_MAX[SAMPLE_BITS-1:0];
        end else if (acc_sh < Y_MIN) begin
            y_sat = Y_MIN[SAMPLE_BITS-1:0];
        end else begin
            y_sat = acc_sh[SAMPLE_BITS-1:0];
        end
    end

    // delay updates, b1 = +/-2*b0 and b2 = b0 reuse b0*x
    always_comb begin
        prod_ext = ACC_BITS'(r_prod);
        bx_ext   = ACC_BITS'(r_bx);
        z2_ext   = ACC_BITS'(r_z2[i_cmd.unit]);
        if (stage) begin
            z1_sum = z2_ext - (bx_ext <<< 1) - prod_ext;
        end else begin
            z1_sum = z2_ext + (bx_ext <<< 1) - prod_ext;
        end
        z2_sum = bx_ext - prod_ext;
        if (z1_sum > D_MAX) begin
            z1_sat = D_MAX[DB-1:0];
        end else if (z1_sum < D_MIN) begin
            z1_sat = D_MIN[DB-1:0];
        end else begin
            z1_sat = z1_sum[DB-1:0];
        end
        if (z2_sum > D_MAX) begin
            z2_sat = D_MAX[DB-1:0];
        end else if (z2_sum < D_MIN) begin
            z2_sat = D_MIN[DB-1:0];
        end else begin
            z2_sat = z2_sum[DB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int u = 0; u < sbq_pkg::NUM_UNITS; u++) begin
                r_z1[u] <= '0;
                r_z2[u] <= '0;
            end
        end else begin
            if (i_cmd.z1_en) begin
                r_z1[i_cmd.unit] <= z1_sat;
            end
            if (i_cmd.z2_en) begin
                r_z2[i_cmd.unit] <= z2_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_x[0] <= i_left_sample;
            r_x[1] <= i_right_sample;
        end else if (i_cmd.acc_en) begin
            r_x[chan] <= y_sat;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_coef * mul_op;
        end
        if (i_cmd.acc_en) begin
            r_y  <= y_sat;
            r_bx <= r_prod;
        end
        if (i_cmd.load_out) begin
            r_out[0] <= r_x[0];
            r_out[1] <= r_x[1];
        end
    end

    assign o_left_result  = r_out[0];
    assign o_right_result = r_out[1];

endmodule

@@ rtl/stereo_biquad_lowpass_highpass_cascade.sv @@
// channel   direction  handshake                  payload
// in        sink       i_in_valid / o_in_stall    i_left_sample, i_right_sample
// out       source     o_out_valid / i_out_stall  o_left_result, o_right_result
// cfg       sink       i_cfg_we                   i_cfg_idx, i_cfg_data
//
// one transaction at a time on a single shared multiplier: accept, then per channel and
// stage a select step and, if enabled, multiply b0, accumulate, multiply a1, multiply a2
// with the z1 update, update z2; then output once the output register is free
// synchronous active-low reset restores config defaults, clears delays and control, no clearing pass
// a finished result waits in the output register; the next transaction is taken meanwhile
module stereo_biquad_lowpass_highpass_cascade #(
    parameter int SAMPLE_BITS     = sbq_pkg::SAMPLE_BITS_DEF,
    parameter int COEFF_FRAC_BITS = sbq_pkg::COEFF_FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]     i_left_sample,
    input  logic signed [SAMPLE_BITS-1:0]     i_right_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]     o_left_result,
    output logic signed [SAMPLE_BITS-1:0]     o_right_result,
    input  logic                              i_cfg_we,
    input  logic [sbq_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [COEFF_FRAC_BITS+2:0]        i_cfg_data
);

    sbq_pkg::t_cmd cmd;
    sbq_pkg::t_sts sts;

    sbq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    sbq_dp #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_left_result  (o_left_result),
        .o_right_result (o_right_result)
    );

endmodule

@@ sim/stereo_biquad_lowpass_highpass_cascade_tb.sv @@
`timescale 1ns / 100ps

module stereo_biquad_lowpass_highpass_cascade_tb;

    localparam int SW       = sbq_pkg::SAMPLE_BITS_DEF;
    localparam int FRAC     = sbq_pkg::COEFF_FRAC_BITS_DEF;
    localparam int CW       = sbq_pkg::COEFF_FRAC_BITS_DEF + 3;
    localparam int LOWPASS  = 0;
    localparam int HIGHPASS = 1;
    localparam int DIR_ROWS = 22;
    localparam int RND_PHASES = 7;
    localparam int PHASE_ITEMS = 100;
    localparam int HOLD_CYCLES = 200;

    typedef logic signed [SW-1:0] t_sample;
    typedef logic [CW-1:0]        t_coef;

    localparam t_sample S_MAX = 24'sh7FFFFF;
    localparam t_sample S_MIN = 24'sh800000;
    localparam t_coef   C_MAX = 25'h0FFFFFF;
    localparam t_coef   C_MIN = 25'h1000000;
    localparam t_coef   C_ONE = 25'h0400000;

    typedef enum int {PRE_BYPASS, PRE_LP_HOT, PRE_HP_WILD, PRE_BOTH_SMOOTH} t_preset;
    typedef enum int {COEF_STABLE, COEF_ANY, COEF_EXTREME} t_coef_style;

    typedef struct {
        t_sample left;
        t_sample right;
    } t_stereo;

    typedef struct {
        t_preset preset;
        t_sample left;
        t_sample right;
        bit      typed;
        t_sample want_l;
        t_sample want_r;
    } t_dir_row;

    typedef struct {
        bit          lp_on;
        bit          hp_on;
        t_coef_style lp_style;
        t_coef_style hp_style;
        bit          quiet;
    } t_rnd_phase;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_in_valid = 1'b0;
    logic    o_in_stall;
    t_sample i_left_sample = '0;
    t_sample i_right_sample = '0;
    logic    o_out_valid;
    logic    i_out_stall = 1'b0;
    t_sample o_left_result;
    t_sample o_right_result;
    logic    i_cfg_we = 1'b0;
    logic [sbq_pkg::CFG_IDX_BITS-1:0] i_cfg_idx = '0;
    t_coef   i_cfg_data = '0;

    stereo_biquad_lowpass_highpass_cascade i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_left_result  (o_left_result),
        .o_right_result (o_right_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // mirror of the filter configuration and delay lines
    bit                   stage_on [2];
    logic signed [CW-1:0] coef_b0 [2];
    logic signed [CW-1:0] coef_a1 [2];
    logic signed [CW-1:0] coef_a2 [2];
    longint               tap1_acc [2][2];
    longint               tap2_acc [2][2];

    t_stereo filtered_q [$];
    t_stereo head;
    int      err_count = 0;
    bit      calm = 1'b0;
    int      hold_ask = 0;
    int      hold_done = 0;
    int      hold_left = 0;

    t_dir_row dir_tab [DIR_ROWS] = '{
        '{PRE_BYPASS, 0, 0, 1'b1, 0, 0},
        '{PRE_BYPASS, S_MAX, S_MIN, 1'b1, S_MAX, S_MIN},
        '{PRE_BYPASS, S_MIN, S_MAX, 1'b1, S_MIN, S_MAX},
        '{PRE_BYPASS, 1, -1, 1'b1, 1, -1},
        '{PRE_BYPASS, 24'sh555555, 24'shAAAAAA, 1'b1, 24'sh555555, 24'shAAAAAA},
        '{PRE_LP_HOT, S_MAX, S_MAX, 1'b0, 0, 0},
        '{PRE_LP_HOT, S_MAX, S_MAX, 1'b0, 0, 0},
        '{PRE_LP_HOT, S_MIN, S_MIN, 1'b0, 0, 0},
        '{PRE_LP_HOT, S_MAX, S_MIN, 1'b0, 0, 0},
        '{PRE_LP_HOT, 0, 0, 1'b0, 0, 0},
        '{PRE_LP_HOT, 1, -1, 1'b0, 0, 0},
        '{PRE_HP_WILD, 100, -100, 1'b0, 0, 0},
        '{PRE_HP_WILD, S_MAX, S_MIN, 1'b0, 0, 0},
        '{PRE_HP_WILD, 0, 0, 1'b0, 0, 0},
        '{PRE_HP_WILD, S_MIN, S_MAX, 1'b0, 0, 0},
        '{PRE_HP_WILD, 0, 0, 1'b0, 0, 0},
        '{PRE_BOTH_SMOOTH, S_MAX, S_MIN, 1'b0, 0, 0},
        '{PRE_BOTH_SMOOTH, S_MAX, S_MIN, 1'b0, 0, 0},
        '{PRE_BOTH_SMOOTH, S_MAX, S_MIN, 1'b0, 0, 0},
        '{PRE_BOTH_SMOOTH, S_MAX, S_MIN, 1'b0, 0, 0},
        '{PRE_BOTH_SMOOTH, S_MIN, S_MAX, 1'b0, 0, 0},
        '{PRE_BOTH_SMOOTH, 0, 0, 1'b0, 0, 0}
    };

    t_rnd_phase rnd_plan [RND_PHASES] = '{
        '{1'b1, 1'b1, COEF_STABLE, COEF_STABLE, 1'b1},
        '{1'b1, 1'b0, COEF_STABLE, COEF_ANY, 1'b0},
        '{1'b0, 1'b1, COEF_ANY, COEF_ANY, 1'b0},
        '{1'b0, 1'b0, COEF_EXTREME, COEF_EXTREME, 1'b0},
        '{1'b1, 1'b1, COEF_EXTREME, COEF_EXTREME, 1'b0},
        '{1'b1, 1'b1, COEF_ANY, COEF_STABLE, 1'b0},
        '{1'b1, 1'b1, COEF_STABLE, COEF_STABLE, 1'b0}
    };

    function automatic longint clamp_bits(longint v, int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) << (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            return hi;
        end
        if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    // one transposed direct form II section, updates the delays of that stage and channel
    function automatic longint biquad_section(int st, int ch, longint x);
        longint b0;
        longint b1;
        longint a1;
        longint a2;
        longint acc;
        longint y;
        b0 = coef_b0[st];
        a1 = coef_a1[st];
        a2 = coef_a2[st];
        b1 = (st == LOWPASS) ? 2 * b0 : -2 * b0;
        acc = b0 * x + tap1_acc[st][ch];
        y = clamp_bits((acc + (longint'(1) << (FRAC - 1))) >>> FRAC, SW);
        tap1_acc[st][ch] = clamp_bits(b1 * x + tap2_acc[st][ch] - a1 * y,
                                      sbq_pkg::DELAY_BITS);
        tap2_acc[st][ch] = clamp_bits(b0 * x - a2 * y, sbq_pkg::DELAY_BITS);
        return y;
    endfunction

    function automatic t_stereo cascade_predict(t_sample l, t_sample r);
        t_stereo res;
        longint  s;
        for (int ch = 0; ch < 2; ch++) begin
            s = (ch == 0) ? longint'(l) : longint'(r);
            for (int st = LOWPASS; st <= HIGHPASS; st++) begin
                if (stage_on[st]) begin
                    s = biquad_section(st, ch, s);
                end
            end
            if (ch == 0) begin
                res.left = s[SW-1:0];
            end else begin
                res.right = s[SW-1:0];
            end
        end
        return res;
    endfunction

    function automatic t_sample draw_sample(t_sample prev);
        longint t;
        t = 0;
        case ($urandom_range(9))
            0, 1, 2, 3: t = longint'(t_sample'($urandom()));
            4, 5, 6: t = longint'(prev) + longint'($urandom_range(200000)) - 100000;
            7: t = longint'($urandom_range(4000)) - 2000;
            8: t = S_MAX;
            default: t = S_MIN;
        endcase
        return t_sample'(clamp_bits(t, SW));
    endfunction

    task automatic pick_coeffs(input t_coef_style style, output t_coef b0, output t_coef a1,
                               output t_coef a2);
        int    mag2;
        int    mag1;
        t_coef picks [4];
        picks = '{C_MAX, C_MIN, C_ONE, '0};
        case (style)
            COEF_STABLE: begin
                mag2 = $urandom_range(1 << 20, (1 << FRAC) - (1 << 18));
                mag1 = $urandom_range(0, (1 << FRAC) + mag2 - (1 << 18));
                a2 = t_coef'(mag2);
                a1 = $urandom_range(1) ? t_coef'(-mag1) : t_coef'(mag1);
                b0 = $urandom_range(1) ? t_coef'(-$urandom_range(1 << 21))
                                       : t_coef'($urandom_range(1 << 21));
            end
            COEF_ANY: begin
                b0 = t_coef'($urandom());
                a1 = t_coef'($urandom());
                a2 = t_coef'($urandom());
            end
            default: begin
                b0 = picks[$urandom_range(3)];
                a1 = picks[$urandom_range(3)];
                a2 = picks[$urandom_range(3)];
            end
        endcase
    endtask

    task automatic flag_mismatch(string what, t_sample got, t_sample want);
        err_count++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    endtask

    // call at a rising edge; the caller lowers the write enable after the last write
    task automatic write_reg(sbq_pkg::t_cfg_idx idx, t_coef val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            sbq_pkg::CFG_LP_EN: stage_on[LOWPASS] = val[0];
            sbq_pkg::CFG_HP_EN: stage_on[HIGHPASS] = val[0];
            sbq_pkg::CFG_LP_B0: coef_b0[LOWPASS] = val;
            sbq_pkg::CFG_LP_A1: coef_a1[LOWPASS] = val;
            sbq_pkg::CFG_LP_A2: coef_a2[LOWPASS] = val;
            sbq_pkg::CFG_HP_B0: coef_b0[HIGHPASS] = val;
            sbq_pkg::CFG_HP_A1: coef_a1[HIGHPASS] = val;
            default:            coef_a2[HIGHPASS] = val;
        endcase
    endtask

    task automatic load_filter(bit lp_on, bit hp_on, t_coef lb0, t_coef la1, t_coef la2,
                               t_coef hb0, t_coef ha1, t_coef ha2);
        write_reg(sbq_pkg::CFG_LP_EN, t_coef'(lp_on));
        write_reg(sbq_pkg::CFG_HP_EN, t_coef'(hp_on));
        write_reg(sbq_pkg::CFG_LP_B0, lb0);
        write_reg(sbq_pkg::CFG_LP_A1, la1);
        write_reg(sbq_pkg::CFG_LP_A2, la2);
        write_reg(sbq_pkg::CFG_HP_B0, hb0);
        write_reg(sbq_pkg::CFG_HP_A1, ha1);
        write_reg(sbq_pkg::CFG_HP_A2, ha2);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_preset(t_preset p);
        case (p)
            PRE_BYPASS:  load_filter(1'b0, 1'b0, C_ONE, '0, '0, C_ONE, '0, '0);
            PRE_LP_HOT:  load_filter(1'b1, 1'b0, C_MAX, '0, '0, C_ONE, '0, '0);
            PRE_HP_WILD: load_filter(1'b0, 1'b1, C_ONE, '0, '0, C_MIN, C_MAX, C_MIN);
            default: load_filter(1'b1, 1'b1, 25'd52429, -25'sd6710886, 25'd2726298,
                                 25'd3407872, -25'sd6710886, 25'd2726298);
        endcase
    endtask

    task automatic send_pair(t_sample l, t_sample r, bit typed, t_sample wl, t_sample wr);
        t_stereo w;
        i_in_valid <= 1'b1;
        i_left_sample <= l;
        i_right_sample <= r;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        w = cascade_predict(l, r);
        if (typed) begin
            w.left = wl;
            w.right = wr;
        end
        filtered_q.push_back(w);
        if (!calm && $urandom_range(99) < 27) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(9) == 0) ? 30 : 4)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (filtered_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // receiver: random stalls, plus a long hold when the sender asks for one
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_ask != hold_done) begin
            hold_done <= hold_ask;
            hold_left <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !calm && ($urandom_range(99) < 27);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (filtered_q.size() == 0) begin
                flag_mismatch("unexpected transaction", o_left_result, '0);
            end else begin
                head = filtered_q.pop_front();
                if (o_left_result !== head.left) begin
                    flag_mismatch("left", o_left_result, head.left);
                end
                if (o_right_result !== head.right) begin
                    flag_mismatch("right", o_right_result, head.right);
                end
            end
        end
    end

    initial begin
        t_dir_row   row;
        t_rnd_phase ph;
        t_preset    cur;
        t_coef      lb0;
        t_coef      la1;
        t_coef      la2;
        t_coef      hb0;
        t_coef      ha1;
        t_coef      ha2;
        t_sample    walk_l;
        t_sample    walk_r;
        cur = PRE_BYPASS;
        walk_l = '0;
        walk_r = '0;
        for (int st = 0; st < 2; st++) begin
            stage_on[st] = 1'b0;
            coef_b0[st] = C_ONE;
            coef_a1[st] = '0;
            coef_a2[st] = '0;
            for (int ch = 0; ch < 2; ch++) begin
                tap1_acc[st][ch] = 0;
                tap2_acc[st][ch] = 0;
            end
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            row = dir_tab[i];
            if (row.preset != cur) begin
                wait_drained();
                apply_preset(row.preset);
                cur = row.preset;
            end
            send_pair(row.left, row.right, row.typed, row.want_l, row.want_r);
        end

        for (int p = 0; p < RND_PHASES; p++) begin
            ph = rnd_plan[p];
            wait_drained();
            pick_coeffs(ph.lp_style, lb0, la1, la2);
            pick_coeffs(ph.hp_style, hb0, ha1, ha2);
            load_filter(ph.lp_on, ph.hp_on, lb0, la1, la2, hb0, ha1, ha2);
            calm <= ph.quiet;
            if (ph.quiet) begin
                hold_ask <= hold_ask + 1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                walk_l = draw_sample(walk_l);
                walk_r = draw_sample(walk_r);
                send_pair(walk_l, walk_r, 1'b0, '0, '0);
            end
        end

        wait_drained();
        calm <= 1'b0;
        repeat (40) @(posedge i_clk);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
